FILE: src/bxavg_pkg.sv
// shared constants and types for the box average downsampler
`default_nettype none

package bxavg_pkg;

  localparam int PIX_W     = 8;
  localparam int FACTOR_W  = 4;
  localparam int NUM_LANES = 3;

  localparam int DEF_OUT_WIDTH  = 64;
  localparam int DEF_OUT_HEIGHT = 32;
  localparam int DEF_MAX_FACTOR = 8;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);

  // sequencer strobes handed to the lanes and the output stage
  typedef struct packed {
    logic take;       // word accepted this cycle
    logic acc_en;     // column sum updated and written back
    logic load;       // first pixel of a block: load instead of add
    logic mul_en;     // reciprocal product registered
    logic out_load;   // averaged word moves into the output register
    logic frame_end;  // marks the last block of a frame
  } ctrl_t;

endpackage

`default_nettype wire

FILE: src/bxavg_pix_if.sv
// input channel: one canvas pixel per word
`default_nettype none

interface bxavg_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bxavg_pkg::PIX_W-1:0] red_in;
  logic [bxavg_pkg::PIX_W-1:0] green_in;
  logic [bxavg_pkg::PIX_W-1:0] blue_in;
  logic                        frame_start;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output frame_start, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input frame_start, output ready);
endinterface

`default_nettype wire

FILE: src/bxavg_avg_if.sv
// output channel: one averaged pixel per word
`default_nettype none

interface bxavg_avg_if;
  logic                        valid;
  logic                        ready;
  logic [bxavg_pkg::PIX_W-1:0] red_out;
  logic [bxavg_pkg::PIX_W-1:0] green_out;
  logic [bxavg_pkg::PIX_W-1:0] blue_out;
  logic                        frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_end, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input frame_end, output ready);
endinterface

`default_nettype wire

FILE: src/bxavg_ram.sv
// generic single write port ram with registered read
`default_nettype none

module bxavg_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/bxavg_lane.sv
// one colour lane: column sum update, reciprocal multiply, saturation
`default_nettype none

module bxavg_lane #(
  parameter int SUM_W = 14,
  parameter int SHIFT = 20,
  parameter int RCP_W = 21
) (
  input  wire logic                        clk,
  input  wire bxavg_pkg::ctrl_t            ctl,
  input  wire logic [bxavg_pkg::PIX_W-1:0] pix,
  input  wire logic [SUM_W-1:0]            rd_sum,
  input  wire logic [RCP_W-1:0]            recip,
  output      logic [SUM_W-1:0]            wr_sum,
  output      logic [bxavg_pkg::PIX_W-1:0] avg
);

  localparam int PROD_W = SUM_W + RCP_W;
  localparam int QUO_W  = PROD_W - SHIFT;

  logic [bxavg_pkg::PIX_W-1:0] pix_r;
  logic [SUM_W-1:0]            sum_r;
  logic [PROD_W-1:0]           prod_r;
  logic [QUO_W-1:0]            quo;

  assign wr_sum = ctl.load ? SUM_W'(pix_r) : rd_sum + SUM_W'(pix_r);

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      pix_r <= pix;
    end
    if (ctl.acc_en) begin
      sum_r <= wr_sum;
    end
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(sum_r) * PROD_W'(recip);
    end
  end

  // rounded-up reciprocal makes the shifted product the exact floor
  assign quo = prod_r[PROD_W-1:SHIFT];
  assign avg = (quo > QUO_W'({bxavg_pkg::PIX_W{1'b1}})) ? {bxavg_pkg::PIX_W{1'b1}}
                                                        : quo[bxavg_pkg::PIX_W-1:0];

endmodule

`default_nettype wire

FILE: src/bxavg_ctrl.sv
// position counters and item sequencer
`default_nettype none

module bxavg_ctrl #(
  parameter int OUT_WIDTH  = bxavg_pkg::DEF_OUT_WIDTH,
  parameter int OUT_HEIGHT = bxavg_pkg::DEF_OUT_HEIGHT,
  parameter int MAX_FACTOR = bxavg_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           in_valid,
  input  wire logic                                           frame_start,
  input  wire logic [bxavg_pkg::FACTOR_W-1:0]                 f_eff,
  input  wire logic                                           slot_free,
  output      logic                                           in_ready,
  output      logic [(OUT_WIDTH > 1 ? $clog2(OUT_WIDTH) : 1)-1:0] rd_addr,
  output      logic [(OUT_WIDTH > 1 ? $clog2(OUT_WIDTH) : 1)-1:0] wr_addr,
  output      bxavg_pkg::ctrl_t                               ctl
);

  localparam int COL_W = OUT_WIDTH > 1 ? $clog2(OUT_WIDTH) : 1;
  localparam int ROW_W = OUT_HEIGHT > 1 ? $clog2(OUT_HEIGHT) : 1;
  localparam int SUB_W = MAX_FACTOR > 1 ? $clog2(MAX_FACTOR) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [SUB_W-1:0] scol_r, scol_nxt, srow_r, srow_nxt;
  logic [COL_W-1:0] ocol_r, ocol_nxt, addr_r;
  logic [ROW_W-1:0] orow_r, orow_nxt;
  logic             load_r, emit_r, fend_r;

  logic [SUB_W-1:0] scol_cur, srow_cur;
  logic [COL_W-1:0] ocol_cur;
  logic [ROW_W-1:0] orow_cur;
  logic             scol_last, srow_last, ocol_last, orow_last;
  logic             take;

  // frame start clears the counters before this pixel is placed
  assign scol_cur = frame_start ? '0 : scol_r;
  assign srow_cur = frame_start ? '0 : srow_r;
  assign ocol_cur = frame_start ? '0 : ocol_r;
  assign orow_cur = frame_start ? '0 : orow_r;

  assign scol_last = (32'(scol_cur) + 32'd1) >= 32'(f_eff);
  assign srow_last = (32'(srow_cur) + 32'd1) >= 32'(f_eff);
  assign ocol_last = 32'(ocol_cur) == OUT_WIDTH - 1;
  assign orow_last = 32'(orow_cur) == OUT_HEIGHT - 1;

  // no word is taken while reset is held
  assign in_ready = rst_n && state_r == ST_IDLE;
  assign take     = in_ready && in_valid;
  assign rd_addr  = ocol_cur;
  assign wr_addr  = addr_r;

  always_comb begin
    scol_nxt = scol_r;
    srow_nxt = srow_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (take) begin
      srow_nxt = srow_cur;
      ocol_nxt = ocol_cur;
      orow_nxt = orow_cur;
      if (!scol_last) begin
        scol_nxt = scol_cur + SUB_W'(1);
      end else begin
        scol_nxt = '0;
        if (!ocol_last) begin
          ocol_nxt = ocol_cur + COL_W'(1);
        end else begin
          ocol_nxt = '0;
          if (!srow_last) begin
            srow_nxt = srow_cur + SUB_W'(1);
          end else begin
            srow_nxt = '0;
            orow_nxt = orow_last ? '0 : orow_cur + ROW_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = emit_r ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scol_r  <= '0;
      srow_r  <= '0;
      ocol_r  <= '0;
      orow_r  <= '0;
      load_r  <= 1'b0;
      emit_r  <= 1'b0;
      fend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scol_r  <= scol_nxt;
      srow_r  <= srow_nxt;
      ocol_r  <= ocol_nxt;
      orow_r  <= orow_nxt;
      if (take) begin
        load_r <= scol_cur == '0 && srow_cur == '0;
        emit_r <= scol_last && srow_last;
        fend_r <= ocol_last && orow_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_r <= ocol_cur;
    end
  end

  always_comb begin
    ctl.take      = take;
    ctl.acc_en    = state_r == ST_ACC;
    ctl.load      = load_r;
    ctl.mul_en    = state_r == ST_MUL;
    ctl.out_load  = (state_r == ST_OUT) && slot_free;
    ctl.frame_end = fend_r;
  end

endmodule

`default_nettype wire

FILE: src/box_average_downsampler.sv
// Box average downsampler: averages factor x factor blocks of a raster canvas.
// in_ch carries one canvas pixel per word (red, green, blue, frame_start) in
// raster order; the canvas is OUT_WIDTH*f wide and OUT_HEIGHT*f high, f being
// cfg_data written with cfg_we (0 acts as 1, above MAX_FACTOR clamps).
// out_ch carries one averaged pixel per block, floor(sum / f*f) saturated to
// 255, with frame_end on the bottom right block. frame_start restarts the
// position counters; after the last block they wrap on their own.
// Per-column running sums sit in a ram of OUT_WIDTH words; three colour lanes
// work in parallel and the output register gathers their results.
// An item that completes no block passes a ram read, then add and write
// back. The last pixel of a block passes read, accumulate, reciprocal
// multiply and output load; its word enters the output register at that load.
// The read-modify-write through the registered ram read sets these steps.
// The output register frees the input side: a new word is taken while the
// previous result waits; a stalled receiver holds the block only when a
// further result is ready to load. Write cfg only while no word is in flight.
// Reset (rst_n low, synchronous) clears counters, sequencer and output valid,
// and sets the factor to 1; the ram needs no clearing.
`default_nettype none

module box_average_downsampler #(
  parameter int OUT_WIDTH  = bxavg_pkg::DEF_OUT_WIDTH,
  parameter int OUT_HEIGHT = bxavg_pkg::DEF_OUT_HEIGHT,
  parameter int MAX_FACTOR = bxavg_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bxavg_pix_if.sink                            in_ch,
  bxavg_avg_if.source                          out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [bxavg_pkg::FACTOR_W-1:0]  cfg_data
);

  localparam int COL_W   = OUT_WIDTH > 1 ? $clog2(OUT_WIDTH) : 1;
  localparam int AREA_LG = 2 * (MAX_FACTOR > 1 ? $clog2(MAX_FACTOR) : 0);
  localparam int SUM_W   = bxavg_pkg::PIX_W + AREA_LG;
  localparam int SHIFT   = SUM_W + AREA_LG;
  localparam int RCP_W   = SHIFT + 1;
  localparam int NF      = 1 << bxavg_pkg::FACTOR_W;
  localparam int NL      = bxavg_pkg::NUM_LANES;

  logic [bxavg_pkg::FACTOR_W-1:0] factor_r, f_eff;
  bxavg_pkg::ctrl_t               ctl;
  logic                           slot_free;
  logic [COL_W-1:0]               rd_addr, wr_addr;
  logic [NL*SUM_W-1:0]            rd_data, wr_data;
  logic [RCP_W-1:0]               recip_tab [NF];
  logic [RCP_W-1:0]               recip;
  logic [bxavg_pkg::PIX_W-1:0]    pix [NL];
  logic [bxavg_pkg::PIX_W-1:0]    avg [NL];

  logic                           out_valid_r;
  logic [bxavg_pkg::PIX_W-1:0]    red_r, green_r, blue_r;
  logic                           fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= bxavg_pkg::FACTOR_RESET;
    end else if (cfg_we) begin
      factor_r <= cfg_data;
    end
  end

  assign f_eff = (factor_r == '0) ? bxavg_pkg::FACTOR_W'(1)
               : (32'(factor_r) > MAX_FACTOR) ? bxavg_pkg::FACTOR_W'(MAX_FACTOR)
               : factor_r;

  // rounded-up reciprocal of f*f for every factor code
  for (genvar g = 0; g < NF; g++) begin : g_rcp
    localparam longint AREA = (g == 0) ? 1 : g * g;
    localparam longint RCP  = ((longint'(1) << SHIFT) + AREA - 1) / AREA;
    assign recip_tab[g] = RCP_W'(RCP);
  end
  assign recip = recip_tab[f_eff];

  assign slot_free = !out_valid_r || out_ch.ready;

  bxavg_ctrl #(
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .frame_start (in_ch.frame_start),
    .f_eff       (f_eff),
    .slot_free   (slot_free),
    .in_ready    (in_ch.ready),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .ctl         (ctl)
  );

  bxavg_ram #(
    .WIDTH (NL * SUM_W),
    .DEPTH (OUT_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (ctl.acc_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.take),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign pix[0] = in_ch.red_in;
  assign pix[1] = in_ch.green_in;
  assign pix[2] = in_ch.blue_in;

  for (genvar l = 0; l < NL; l++) begin : g_lane
    bxavg_lane #(
      .SUM_W (SUM_W),
      .SHIFT (SHIFT),
      .RCP_W (RCP_W)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .pix    (pix[l]),
      .rd_sum (rd_data[l*SUM_W +: SUM_W]),
      .recip  (recip),
      .wr_sum (wr_data[l*SUM_W +: SUM_W]),
      .avg    (avg[l])
    );
  end

  // output register gathers the three lanes into one word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      red_r   <= avg[0];
      green_r <= avg[1];
      blue_r  <= avg[2];
      fend_r  <= ctl.frame_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = red_r;
  assign out_ch.green_out = green_r;
  assign out_ch.blue_out  = blue_r;
  assign out_ch.frame_end = fend_r;

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_ch.ready))
    else $error("output word overwritten before it was taken");

  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word accepted while a sum update is pending");

  a_write_after_read : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc_en |-> $past(ctl.take))
    else $error("column sum written without a preceding read");

  a_mul_after_acc : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mul_en |-> $past(ctl.acc_en))
    else $error("average computed without a fresh block sum");

endmodule

`default_nettype wire
